FILE: design/nmr_pkg.sv
// Shared widths, constants and stage payload types for the normal-map texel renormalizer.
// No dependencies; used by every module under design/.
package nmr_pkg;

    localparam int CH_W  = 8;
    localparam int NCH   = 3;
    localparam int MAG_W = 7;
    localparam int SQ_W  = 15;
    localparam int SUM_W = 16;
    localparam int NUM_W = 28;
    localparam int DEN_W = 14;
    localparam int SCL_W = 29;
    localparam int A_W   = 42;
    localparam int Q_W   = 36;
    localparam int P_W   = 44;
    localparam int ALU_W = 11;

    localparam logic [CH_W-1:0]  BIAS   = 8'd128;
    // 12699^2 and 100^2: scale 126.99 squared as an exact ratio
    localparam logic [NUM_W-1:0] NUM_SQ = 28'd161264601;
    localparam logic [DEN_W-1:0] DEN_SQ = 14'd10000;

    typedef struct packed {
        logic             neg;
        logic             zero;
        logic [A_W-1:0]   a;
        logic [MAG_W-1:0] m;
        logic [A_W-1:0]   p;
        logic [Q_W-1:0]   q;
    } srch_ch_t;

    typedef struct packed {
        logic [SCL_W-1:0]         sden;
        srch_ch_t [NCH-1:0]       ch;
    } srch_t;

endpackage

FILE: design/nmr_prep.sv
// Front three stages: bias removal and squares, sum and scaled target, scaled length.
// Depends on nmr_pkg.
module nmr_prep
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [nmr_pkg::CH_W-1:0]   in_red,
    input  logic [nmr_pkg::CH_W-1:0]   in_green,
    input  logic [nmr_pkg::CH_W-1:0]   in_blue,
    output logic                       out_valid,
    input  logic                       out_ready,
    output nmr_pkg::srch_t             out_word
);

    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    logic [nmr_pkg::CH_W-1:0] chan [nmr_pkg::NCH];

    logic [nmr_pkg::SQ_W-1:0] sq_next  [nmr_pkg::NCH];
    logic [nmr_pkg::NCH-1:0]  neg_next, zero_next;
    logic [nmr_pkg::SQ_W-1:0] sq_reg   [nmr_pkg::NCH];
    logic [nmr_pkg::NCH-1:0]  neg1_reg, zero1_reg;

    logic [nmr_pkg::SUM_W-1:0] s_next;
    logic [nmr_pkg::A_W-1:0]   a_next  [nmr_pkg::NCH];
    logic [nmr_pkg::SUM_W-1:0] s_reg;
    logic [nmr_pkg::A_W-1:0]   a2_reg  [nmr_pkg::NCH];
    logic [nmr_pkg::NCH-1:0]   neg2_reg, zero2_reg;

    logic [nmr_pkg::SCL_W-1:0] sden_next;
    logic [nmr_pkg::SCL_W-1:0] sden_reg;
    logic [nmr_pkg::A_W-1:0]   a3_reg  [nmr_pkg::NCH];
    logic [nmr_pkg::NCH-1:0]   neg3_reg, zero3_reg;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    assign chan[0] = in_red;
    assign chan[1] = in_green;
    assign chan[2] = in_blue;

    always_comb
    begin
        logic [nmr_pkg::CH_W-1:0]     absv;
        logic [2*nmr_pkg::CH_W-1:0]   prod;
        logic [nmr_pkg::SQ_W+nmr_pkg::NUM_W-1:0] aprod;
        logic [nmr_pkg::SUM_W+nmr_pkg::DEN_W-1:0] sprod;
        for (int i = 0; i < nmr_pkg::NCH; i++)
        begin
            absv = (chan[i] >= nmr_pkg::BIAS) ? (chan[i] - nmr_pkg::BIAS)
                                              : (nmr_pkg::BIAS - chan[i]);
            prod = {{nmr_pkg::CH_W{1'b0}}, absv} * {{nmr_pkg::CH_W{1'b0}}, absv};
            sq_next[i]   = prod[nmr_pkg::SQ_W-1:0];
            neg_next[i]  = (chan[i] < nmr_pkg::BIAS);
            zero_next[i] = (chan[i] == nmr_pkg::BIAS);
        end
        s_next = {1'b0, sq_reg[0]} + {1'b0, sq_reg[1]} + {1'b0, sq_reg[2]};
        for (int i = 0; i < nmr_pkg::NCH; i++)
        begin
            aprod = {{nmr_pkg::NUM_W{1'b0}}, sq_reg[i]}
                  * {{nmr_pkg::SQ_W{1'b0}}, nmr_pkg::NUM_SQ};
            a_next[i] = aprod[nmr_pkg::A_W-1:0];
        end
        sprod = {{nmr_pkg::DEN_W{1'b0}}, s_reg} * {{nmr_pkg::SUM_W{1'b0}}, nmr_pkg::DEN_SQ};
        sden_next = sprod[nmr_pkg::SCL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            sq_reg    <= sq_next;
            neg1_reg  <= neg_next;
            zero1_reg <= zero_next;
        end
        if (rdy2 && v1_reg)
        begin
            s_reg     <= s_next;
            a2_reg    <= a_next;
            neg2_reg  <= neg1_reg;
            zero2_reg <= zero1_reg;
        end
        if (rdy3 && v2_reg)
        begin
            sden_reg  <= sden_next;
            a3_reg    <= a2_reg;
            neg3_reg  <= neg2_reg;
            zero3_reg <= zero2_reg;
        end
    end

    always_comb
    begin
        out_word.sden = sden_reg;
        for (int i = 0; i < nmr_pkg::NCH; i++)
        begin
            out_word.ch[i].neg  = neg3_reg[i];
            out_word.ch[i].zero = zero3_reg[i];
            out_word.ch[i].a    = a3_reg[i];
            out_word.ch[i].m    = '0;
            out_word.ch[i].p    = '0;
            out_word.ch[i].q    = '0;
        end
    end

    assign out_valid = v3_reg;

endmodule

FILE: design/nmr_search_stage.sv
// One digit of the magnitude search: tries bit J of m for all channels, largest m with
// m^2*sden <= a, tracking m^2*sden and m*sden incrementally. Depends on nmr_pkg.
module nmr_search_stage
#(
    parameter int J = 0
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  nmr_pkg::srch_t  in_word,
    output logic            out_valid,
    input  logic            out_ready,
    output nmr_pkg::srch_t  out_word
);

    logic           valid_reg;
    nmr_pkg::srch_t word_reg;
    nmr_pkg::srch_t word_next;
    logic           rdy;

    assign rdy      = !valid_reg || out_ready;
    assign in_ready = rdy;

    always_comb
    begin
        logic [nmr_pkg::P_W-1:0] cand;
        logic [nmr_pkg::P_W-1:0] lim;
        word_next = in_word;
        for (int i = 0; i < nmr_pkg::NCH; i++)
        begin
            // (k + 2^J)^2 S = k^2 S + k S 2^(J+1) + S 2^(2J)
            cand = {2'b00, in_word.ch[i].p}
                 + ({{(nmr_pkg::P_W-nmr_pkg::Q_W){1'b0}}, in_word.ch[i].q} << (J + 1))
                 + ({{(nmr_pkg::P_W-nmr_pkg::SCL_W){1'b0}}, in_word.sden} << (2 * J));
            lim  = {2'b00, in_word.ch[i].a};
            if (cand <= lim)
            begin
                word_next.ch[i].m = in_word.ch[i].m | (nmr_pkg::MAG_W'(1) << J);
                word_next.ch[i].p = cand[nmr_pkg::A_W-1:0];
                word_next.ch[i].q = in_word.ch[i].q
                    + ({{(nmr_pkg::Q_W-nmr_pkg::SCL_W){1'b0}}, in_word.sden} << J);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (rdy)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (rdy && in_valid)
            word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

FILE: design/nmr_finish.sv
// Output register: rebias magnitudes with sign, zero-component case, alpha.
// Depends on nmr_pkg.
module nmr_finish
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  nmr_pkg::srch_t            in_word,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [nmr_pkg::CH_W-1:0]  out_red,
    output logic [nmr_pkg::CH_W-1:0]  out_green,
    output logic [nmr_pkg::CH_W-1:0]  out_blue,
    output logic [nmr_pkg::CH_W-1:0]  out_alpha
);

    logic                     valid_reg;
    logic                     rdy;
    logic [nmr_pkg::CH_W-1:0] chan_next [nmr_pkg::NCH];
    logic [nmr_pkg::CH_W-1:0] alpha_next;
    logic [nmr_pkg::CH_W-1:0] chan_reg  [nmr_pkg::NCH];
    logic [nmr_pkg::CH_W-1:0] alpha_reg;

    assign rdy      = !valid_reg || out_ready;
    assign in_ready = rdy;

    always_comb
    begin
        logic [nmr_pkg::CH_W-1:0]  mext;
        logic [nmr_pkg::ALU_W-1:0] diff;
        logic [nmr_pkg::ALU_W-1:0] adj;
        for (int i = 0; i < nmr_pkg::NCH; i++)
        begin
            mext = {1'b0, in_word.ch[i].m};
            if (in_word.ch[i].zero)
                chan_next[i] = nmr_pkg::BIAS;
            else if (in_word.ch[i].neg)
                chan_next[i] = nmr_pkg::BIAS - mext;
            else
                chan_next[i] = nmr_pkg::BIAS + mext;
        end
        diff = {3'b000, nmr_pkg::BIAS} - {3'b000, chan_next[0]}
             - {3'b000, chan_next[1]} - {3'b000, chan_next[2]};
        // halve toward zero
        adj  = diff + {{(nmr_pkg::ALU_W-1){1'b0}}, diff[nmr_pkg::ALU_W-1]};
        alpha_next = adj[nmr_pkg::CH_W:1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (rdy)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (rdy && in_valid)
        begin
            chan_reg  <= chan_next;
            alpha_reg <= alpha_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_red   = chan_reg[0];
    assign out_green = chan_reg[1];
    assign out_blue  = chan_reg[2];
    assign out_alpha = alpha_reg;

endmodule

FILE: design/normal_map_texel_renormalizer_top.sv
// Top level of the normal-map texel renormalizer: prep stages, seven search stages, output.
// Depends on nmr_pkg, nmr_prep, nmr_search_stage, nmr_finish.
//
// Takes one RGB8 normal-map texel per cycle and returns it rescaled to a length just under
// 127 around the 128 bias, with alpha = (128 - r - g - b) / 2 truncated, modulo 256. Each
// word passes through three front stages (squares, sum and scaled target, scaled length),
// one stage per bit of the 7-bit magnitude, and the output register. A new word is taken
// every cycle unless stalled; every stage has its own valid bit and holds only while the
// stage after it is full and stalled, so out_ready low backs up the pipe one stage at a time.
module normal_map_texel_renormalizer_top
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [nmr_pkg::CH_W-1:0]  in_red,
    input  logic [nmr_pkg::CH_W-1:0]  in_green,
    input  logic [nmr_pkg::CH_W-1:0]  in_blue,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [nmr_pkg::CH_W-1:0]  out_red,
    output logic [nmr_pkg::CH_W-1:0]  out_green,
    output logic [nmr_pkg::CH_W-1:0]  out_blue,
    output logic [nmr_pkg::CH_W-1:0]  out_alpha
);

    localparam int NSTG = nmr_pkg::MAG_W;

    logic           vld  [NSTG+1];
    logic           rdy  [NSTG+1];
    nmr_pkg::srch_t word [NSTG+1];

    nmr_prep u_prep
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_red    (in_red),
        .in_green  (in_green),
        .in_blue   (in_blue),
        .out_valid (vld[0]),
        .out_ready (rdy[0]),
        .out_word  (word[0])
    );

    for (genvar g = 0; g < NSTG; g++)
    begin : g_srch
        nmr_search_stage
        #(
            .J (NSTG - 1 - g)
        )
        u_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (vld[g]),
            .in_ready  (rdy[g]),
            .in_word   (word[g]),
            .out_valid (vld[g+1]),
            .out_ready (rdy[g+1]),
            .out_word  (word[g+1])
        );
    end

    nmr_finish u_finish
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld[NSTG]),
        .in_ready  (rdy[NSTG]),
        .in_word   (word[NSTG]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue),
        .out_alpha (out_alpha)
    );

endmodule

FILE: test/normal_map_texel_renormalizer_top_tb.sv
// Testbench for normal_map_texel_renormalizer_top: sends RGB8 texels with random idling and
// checks each output word against a local renormalization predictor, in order.
// Depends on nmr_pkg and the design under design/.
module normal_map_texel_renormalizer_top_tb;

    localparam int unsigned SCALE_NUM   = 12699;
    localparam int unsigned SCALE_DEN   = 100;
    localparam int          MAG_MAX     = 127;
    localparam int          HOLD_CYCLES = 150;
    localparam int          SETTLE      = 20;

    typedef logic [nmr_pkg::CH_W-1:0] chan_t;

    typedef struct {
        chan_t red;
        chan_t green;
        chan_t blue;
        chan_t alpha;
    } texel_t;

    logic  clk;
    logic  rst_n;
    logic  in_valid;
    logic  in_ready;
    chan_t in_red;
    chan_t in_green;
    chan_t in_blue;
    logic  out_valid;
    logic  out_ready;
    chan_t out_red;
    chan_t out_green;
    chan_t out_blue;
    chan_t out_alpha;

    texel_t pending_texels[$];
    texel_t want;
    int     mismatches = 0;
    bit     idle_in    = 0;
    bit     idle_out   = 0;
    bit     hold_req   = 0;

    normal_map_texel_renormalizer_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_red    (in_red),
        .in_green  (in_green),
        .in_blue   (in_blue),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue),
        .out_alpha (out_alpha)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #800000;
        $display("normal_map_texel_renormalizer_top: mismatch");
        $finish;
    end

    // largest m with (100m)^2 * s <= (12699|v|)^2, sign taken from v
    function automatic chan_t renorm_channel(int v, longint unsigned s);
        longint unsigned av;
        longint unsigned rhs;
        longint unsigned t;
        int              m;
        if (s == 0)
            return nmr_pkg::BIAS;
        av  = longint'(v < 0 ? -v : v);
        rhs = (SCALE_NUM * av) * (SCALE_NUM * av);
        m   = 0;
        for (int k = 1; k <= MAG_MAX; k++)
        begin
            t = SCALE_DEN * k;
            if (t * t * s <= rhs)
                m = k;
            else
                break;
        end
        return (v < 0) ? chan_t'(int'(nmr_pkg::BIAS) - m)
                       : chan_t'(int'(nmr_pkg::BIAS) + m);
    endfunction

    function automatic texel_t renorm_texel(chan_t r, chan_t g, chan_t b);
        int              vx;
        int              vy;
        int              vz;
        longint unsigned s;
        int              diff;
        int              q;
        texel_t          res;
        vx = int'(r) - int'(nmr_pkg::BIAS);
        vy = int'(g) - int'(nmr_pkg::BIAS);
        vz = int'(b) - int'(nmr_pkg::BIAS);
        s  = longint'(vx * vx + vy * vy + vz * vz);
        res.red   = renorm_channel(vx, s);
        res.green = renorm_channel(vy, s);
        res.blue  = renorm_channel(vz, s);
        diff = int'(nmr_pkg::BIAS) - int'(res.red) - int'(res.green) - int'(res.blue);
        q    = diff / 2;
        res.alpha = q[nmr_pkg::CH_W-1:0];
        return res;
    endfunction

    // entered at a falling edge; leaves in_valid high so back-to-back words stay valid
    task automatic send_texel(chan_t r, chan_t g, chan_t b);
        int gap;
        gap = idle_in ? $urandom_range(0, 16) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_red   <= r;
        in_green <= g;
        in_blue  <= b;
        do @(posedge clk); while (!in_ready);
        pending_texels.push_back(renorm_texel(r, g, b));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_texels.size() != 0)
            @(negedge clk);
    endtask

    // 0: any value, 1: near the bias (short vectors), 2: edge values
    function automatic chan_t draw_channel(int kind);
        chan_t edges[7] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd129, 8'd254, 8'd255};
        case (kind)
            1:       return chan_t'(int'(nmr_pkg::BIAS) + $urandom_range(0, 8) - 4);
            2:       return edges[$urandom_range(0, 6)];
            default: return chan_t'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int draw_kind();
        int p;
        p = $urandom_range(0, 9);
        return (p < 6) ? 0 : (p < 8) ? 1 : 2;
    endfunction

    task automatic test_directed();
        idle_in  = 0;
        idle_out = 0;
        send_texel(8'd128, 8'd128, 8'd128);
        send_texel(8'd0,   8'd0,   8'd0);
        send_texel(8'd255, 8'd255, 8'd255);
        send_texel(8'd0,   8'd255, 8'd128);
        send_texel(8'd0,   8'd128, 8'd128);
        send_texel(8'd255, 8'd128, 8'd128);
        send_texel(8'd128, 8'd0,   8'd128);
        send_texel(8'd128, 8'd255, 8'd128);
        send_texel(8'd128, 8'd128, 8'd0);
        send_texel(8'd128, 8'd128, 8'd255);
        send_texel(8'd129, 8'd128, 8'd128);
        send_texel(8'd127, 8'd128, 8'd128);
        send_texel(8'd129, 8'd129, 8'd129);
        send_texel(8'd127, 8'd127, 8'd127);
        send_texel(8'd128, 8'd0,   8'd255);
        send_texel(8'd255, 8'd0,   8'd128);
        send_texel(8'd1,   8'd254, 8'd127);
        send_texel(8'd170, 8'd85,  8'd255);
        send_texel(8'd129, 8'd127, 8'd255);
        send_texel(8'd0,   8'd255, 8'd0);
        wait_drained();
    endtask

    task automatic test_random(int count, bit gaps_in, bit gaps_out);
        idle_in  = gaps_in;
        idle_out = gaps_out;
        repeat (count)
            send_texel(draw_channel(draw_kind()), draw_channel(draw_kind()),
                       draw_channel(draw_kind()));
    endtask

    // receiver holds off while the sender keeps offering, so the pipe backs up to in_ready
    task automatic test_backpressure();
        idle_in  = 0;
        idle_out = 0;
        hold_req = 1;
        repeat (48)
            send_texel(draw_channel(0), draw_channel(0), draw_channel(0));
        wait_drained();
    endtask

    task automatic test_drain_pause();
        test_random(20, 1, 1);
        wait_drained();
        test_random(20, 0, 1);
        wait_drained();
    endtask

    initial
    begin
        int stall;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 0;
            end
            stall = idle_out ? $urandom_range(0, 16) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_texels.size() == 0)
            begin
                $error("unexpected word: red %0d green %0d blue %0d alpha %0d",
                       out_red, out_green, out_blue, out_alpha);
                mismatches++;
            end
            else
            begin
                want = pending_texels.pop_front();
                if (out_red !== want.red)
                begin
                    $error("out_red: expected %0d, got %0d", want.red, out_red);
                    mismatches++;
                end
                if (out_green !== want.green)
                begin
                    $error("out_green: expected %0d, got %0d", want.green, out_green);
                    mismatches++;
                end
                if (out_blue !== want.blue)
                begin
                    $error("out_blue: expected %0d, got %0d", want.blue, out_blue);
                    mismatches++;
                end
                if (out_alpha !== want.alpha)
                begin
                    $error("out_alpha: expected %0d, got %0d", want.alpha, out_alpha);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_red   <= '0;
        in_green <= '0;
        in_blue  <= '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_random(400, 1, 1);
        test_drain_pause();
        test_backpressure();
        test_random(300, 0, 0);
        test_random(150, 1, 0);
        test_random(150, 0, 1);
        wait_drained();
        repeat (SETTLE) @(negedge clk);

        if (mismatches == 0)
            $display("normal_map_texel_renormalizer_top: match");
        else
            $display("normal_map_texel_renormalizer_top: mismatch");
        $finish;
    end

endmodule

FILE: normal_map_texel_renormalizer_top.f
design/nmr_pkg.sv
design/nmr_prep.sv
design/nmr_search_stage.sv
design/nmr_finish.sv
design/normal_map_texel_renormalizer_top.sv
test/normal_map_texel_renormalizer_top_tb.sv
